>>> rtl/hvng_pkg.sv
// hvng_pkg: shared types, constants and register codes for the height-field
// vertex and normal generator; no dependencies
package hvng_pkg;

  localparam int MaxVertsPerRow = 256;
  localparam int ColW           = $clog2(MaxVertsPerRow);
  localparam int HW             = 16;
  localparam int PosW           = 25;
  localparam int NrmW           = 16;
  localparam int AddrW          = 4;
  localparam int DataW          = 32;

  localparam logic signed [NrmW-1:0] NRM_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    REG_BLOCKS_ACROSS = 2'd0,
    REG_BLOCKS_DOWN   = 2'd1,
    REG_CELL_WIDTH    = 2'd2,
    REG_CELL_DEPTH    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]  blocks_across;
    logic [7:0]  blocks_down;
    logic [15:0] cell_width;
    logic [15:0] cell_depth;
  } cfg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEL,
    S_POS,
    S_NORM,
    S_OUT,
    S_UPD
  } ctrl_state_t;

  typedef enum logic [2:0] {
    N_IDLE,
    N_SHIFT,
    N_SQ,
    N_SQRT,
    N_DSET,
    N_DIV,
    N_DONE
  } norm_state_t;

  typedef struct packed {
    logic accept;
    logic sel;
    logic pos;
    logic upd;
  } cmd_t;

  typedef struct packed {
    logic any_pending;
    logic cur_int;
    logic norm_done;
  } status_t;

endpackage

>>> rtl/hvng_norm.sv
// hvng_norm: iterative unit normal of a gradient vector, q1.14 output
// shift search, squares, bit-serial square root and three long divisions; uses hvng_pkg
module hvng_norm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic signed [16:0]             v_x,
  input  logic [17:0]                    v_y,
  input  logic signed [16:0]             v_z,
  output logic                           done,
  output logic signed [hvng_pkg::NrmW-1:0] n_x,
  output logic signed [hvng_pkg::NrmW-1:0] n_y,
  output logic signed [hvng_pkg::NrmW-1:0] n_z
);
  import hvng_pkg::*;

  norm_state_t state;
  logic [17:0] m0, m1, m2;
  logic        s0, s2;
  logic [1:0]  k;
  logic [1:0]  j;
  logic [4:0]  i;
  logic [35:0] prod;
  logic [37:0] s2acc;
  logic [53:0] rv;
  logic [53:0] res;
  logic [53:0] bitr;
  logic [26:0] len;
  logic [27:0] rem;
  logic [16:0] dlo;
  logic [16:0] q;

  logic [17:0] msel_sq;
  logic [17:0] msel_div;
  logic        sgn_div;
  logic [37:0] acc;
  logic [53:0] trial;
  logic        sq_ge;
  logic [53:0] res_next;
  logic [40:0] dvd;
  logic [27:0] rem2;
  logic        d_ge;
  logic [16:0] q_next;
  logic [NrmW-1:0] qc;
  logic [NrmW-1:0] nval;

  always_comb begin
    unique case (k)
      2'd0:    msel_sq = m0;
      2'd1:    msel_sq = m1;
      2'd2:    msel_sq = m2;
      default: msel_sq = '0;
    endcase
    unique case (j)
      2'd0:    begin msel_div = m0; sgn_div = s0; end
      2'd1:    begin msel_div = m1; sgn_div = 1'b0; end
      default: begin msel_div = m2; sgn_div = s2; end
    endcase
    acc      = s2acc + {2'b0, prod};
    trial    = res + bitr;
    sq_ge    = (rv >= trial);
    res_next = sq_ge ? ((res >> 1) + bitr) : (res >> 1);
    dvd      = {1'b0, msel_div, 22'b0} + {15'b0, len[26:1]};
    rem2     = {rem[26:0], dlo[16]};
    d_ge     = (rem2 >= {1'b0, len});
    q_next   = {q[15:0], d_ge};
    qc       = (q_next > 17'd16384) ? 16'd16384 : q_next[15:0];
    nval     = sgn_div ? (16'd0 - qc) : qc;
  end

  assign done = (state == N_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      unique case (state)
        N_IDLE:  if (start) state <= N_SHIFT;
        N_SHIFT: if (m0[17] | m1[17] | m2[17]) state <= N_SQ;
        N_SQ:    if (k == 2'd3) state <= N_SQRT;
        N_SQRT:  if (i == 5'd0) state <= N_DSET;
        N_DSET:  state <= N_DIV;
        N_DIV:   if (i == 5'd0 && j == 2'd2) state <= N_DONE;
                 else if (i == 5'd0) state <= N_DSET;
        N_DONE:  state <= N_IDLE;
        default: state <= N_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      N_IDLE: begin
        if (start) begin
          m0    <= v_x[16] ? 18'(-{v_x[16], v_x}) : {1'b0, v_x};
          m1    <= v_y;
          m2    <= v_z[16] ? 18'(-{v_z[16], v_z}) : {1'b0, v_z};
          s0    <= v_x[16];
          s2    <= v_z[16];
          k     <= 2'd0;
          s2acc <= '0;
        end
      end
      N_SHIFT: begin
        if (!(m0[17] | m1[17] | m2[17])) begin
          m0 <= m0 << 1;
          m1 <= m1 << 1;
          m2 <= m2 << 1;
        end
      end
      N_SQ: begin
        prod <= msel_sq * msel_sq;
        if (k != 2'd0) s2acc <= acc;
        k <= k + 2'd1;
        if (k == 2'd3) begin
          rv   <= {acc[37:0], 16'b0};
          res  <= '0;
          bitr <= 54'd1 << 52;
          i    <= 5'd26;
        end
      end
      N_SQRT: begin
        if (sq_ge) rv <= rv - trial;
        res  <= res_next;
        bitr <= bitr >> 2;
        i    <= i - 5'd1;
        if (i == 5'd0) begin
          len <= res_next[26:0];
          j   <= 2'd0;
        end
      end
      N_DSET: begin
        rem <= {4'b0, dvd[40:17]};
        dlo <= dvd[16:0];
        q   <= '0;
        i   <= 5'd16;
      end
      N_DIV: begin
        rem <= d_ge ? (rem2 - {1'b0, len}) : rem2;
        dlo <= dlo << 1;
        q   <= q_next;
        i   <= i - 5'd1;
        if (i == 5'd0) begin
          unique case (j)
            2'd0:    n_x <= nval;
            2'd1:    n_y <= nval;
            default: n_z <= nval;
          endcase
          j <= j + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/hvng_datapath.sv
// hvng_datapath: line buffers, window, counters, result selection, positions
// and output registers; uses hvng_pkg and hvng_norm
module hvng_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  hvng_pkg::cfg_t                  cfg,
  input  hvng_pkg::cmd_t                  cmd,
  output hvng_pkg::status_t               status,
  input  logic signed [hvng_pkg::HW-1:0]  height,
  output logic [7:0]                      vertex_col,
  output logic [7:0]                      vertex_row,
  output logic signed [hvng_pkg::PosW-1:0] pos_x,
  output logic signed [hvng_pkg::HW-1:0]  pos_y,
  output logic signed [hvng_pkg::PosW-1:0] pos_z,
  output logic signed [hvng_pkg::NrmW-1:0] normal_x,
  output logic signed [hvng_pkg::NrmW-1:0] normal_y,
  output logic signed [hvng_pkg::NrmW-1:0] normal_z,
  output logic                            run_last,
  output logic                            grid_done
);
  import hvng_pkg::*;

  logic [HW-1:0] older_row_store [MaxVertsPerRow];
  logic [HW-1:0] newer_row_store [MaxVertsPerRow];

  logic [ColW-1:0] col_cnt, row_cnt;
  logic [ColW-1:0] c, r;
  logic [HW-1:0]   h_q, top_q, mid_q, w0, w1, w2, w4;
  logic [3:0]      pending;

  logic [ColW-1:0] cur_row, cur_col;
  logic [HW-1:0]   cur_h;
  logic            cur_int, cur_last, cur_done;
  logic [PosW-1:0] px, pz;

  logic [ColW-1:0] sel_row, sel_col;
  logic [HW-1:0]   sel_h;
  logic            sel_int, sel_done;
  logic [3:0]      sel_clr;

  logic signed [9:0]  sx, sz;
  logic signed [26:0] prod_x, prod_z;
  logic [26:0]        sum_x, sum_z;

  logic signed [16:0] v_x, v_z;
  logic [17:0]        v_y;
  logic               n_done;
  logic signed [NrmW-1:0] n_x, n_y, n_z;

  assign c = (col_cnt > cfg.blocks_across) ? cfg.blocks_across : col_cnt;
  assign r = (row_cnt > cfg.blocks_down) ? cfg.blocks_down : row_cnt;

  always_comb begin
    sel_row  = r - 8'd1;
    sel_col  = c - 8'd1;
    sel_h    = w1;
    sel_int  = (c >= 8'd2) && (r >= 8'd2);
    sel_done = 1'b0;
    sel_clr  = 4'b0001;
    priority if (pending[0]) begin
    end else if (pending[1]) begin
      sel_col = c;
      sel_h   = mid_q;
      sel_int = 1'b0;
      sel_clr = 4'b0010;
    end else if (pending[2]) begin
      sel_row = r;
      sel_h   = w2;
      sel_int = 1'b0;
      sel_clr = 4'b0100;
    end else begin
      sel_row  = r;
      sel_col  = c;
      sel_h    = h_q;
      sel_int  = 1'b0;
      sel_done = 1'b1;
      sel_clr  = 4'b1000;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      top_q <= older_row_store[c];
      mid_q <= newer_row_store[c];
    end
    if (cmd.upd) begin
      older_row_store[c] <= mid_q;
      newer_row_store[c] <= h_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      pending <= '0;
      w0 <= '0;
      w1 <= '0;
      w2 <= '0;
      w4 <= '0;
    end else begin
      if (cmd.accept) begin
        pending <= {(r == cfg.blocks_down) && (c == cfg.blocks_across),
                    (r == cfg.blocks_down) && (c != 8'd0),
                    (r != 8'd0) && (c == cfg.blocks_across),
                    (r != 8'd0) && (c != 8'd0)};
      end else if (cmd.sel) begin
        pending <= pending & ~sel_clr;
      end
      if (cmd.upd) begin
        w4 <= w1;
        w0 <= top_q;
        w1 <= mid_q;
        w2 <= h_q;
        if (c >= cfg.blocks_across) begin
          col_cnt <= '0;
          row_cnt <= (r >= cfg.blocks_down) ? '0 : r + 8'd1;
        end else begin
          col_cnt <= c + 8'd1;
          row_cnt <= r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) h_q <= height;
    if (cmd.sel) begin
      cur_row  <= sel_row;
      cur_col  <= sel_col;
      cur_h    <= sel_h;
      cur_int  <= sel_int;
      cur_done <= sel_done;
      cur_last <= ((pending & ~sel_clr) == 4'b0);
    end
    if (cmd.pos) begin
      px <= sum_x[25:1];
      pz <= sum_z[25:1];
    end
  end

  // positions: halving rounds toward +inf
  assign sx     = $signed({1'b0, cur_col, 1'b0}) - $signed({2'b0, cfg.blocks_across});
  assign sz     = $signed({2'b0, cfg.blocks_down}) - $signed({1'b0, cur_row, 1'b0});
  assign prod_x = $signed({1'b0, cfg.cell_width}) * sx;
  assign prod_z = $signed({1'b0, cfg.cell_depth}) * sz;
  assign sum_x  = prod_x + 27'sd1;
  assign sum_z  = prod_z + 27'sd1;

  assign v_x = $signed({w4[15], w4}) - $signed({mid_q[15], mid_q});
  assign v_z = $signed({w2[15], w2}) - $signed({w0[15], w0});
  assign v_y = {({1'b0, cfg.cell_width} + {1'b0, cfg.cell_depth}), 1'b0};

  hvng_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.pos & cur_int),
    .v_x   (v_x),
    .v_y   (v_y),
    .v_z   (v_z),
    .done  (n_done),
    .n_x   (n_x),
    .n_y   (n_y),
    .n_z   (n_z)
  );

  assign status.any_pending = |pending;
  assign status.cur_int     = cur_int;
  assign status.norm_done   = n_done;

  assign vertex_col = cur_col;
  assign vertex_row = cur_row;
  assign pos_x      = px;
  assign pos_y      = cur_h;
  assign pos_z      = pz;
  assign normal_x   = cur_int ? n_x : '0;
  assign normal_y   = cur_int ? n_y : NRM_ONE;
  assign normal_z   = cur_int ? n_z : '0;
  assign run_last   = cur_last;
  assign grid_done  = cur_done;

endmodule

>>> rtl/hvng_ctrl.sv
// hvng_ctrl: sequencer for item intake, result selection, normal wait,
// output handshake and line buffer update; uses hvng_pkg
module hvng_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  hvng_pkg::status_t   status,
  output hvng_pkg::cmd_t      cmd
);
  import hvng_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_SEL;
      S_SEL:  state_next = status.any_pending ? S_POS : S_UPD;
      S_POS:  state_next = status.cur_int ? S_NORM : S_OUT;
      S_NORM: if (status.norm_done) state_next = S_OUT;
      S_OUT:  if (!out_stall) state_next = S_SEL;
      S_UPD:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = (state != S_IDLE);
    out_valid  = (state == S_OUT);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.sel    = (state == S_SEL) && status.any_pending;
    cmd.pos    = (state == S_POS);
    cmd.upd    = (state == S_UPD);
  end

endmodule

>>> rtl/heightfield_vertex_normal_gen.sv
// heightfield_vertex_normal_gen: top level with configuration registers
// uses hvng_pkg, hvng_ctrl, hvng_datapath (and hvng_norm beneath it)
//
//   channel  | signals                                   | direction
//   input    | in_valid, in_stall, height                | item in
//   output   | out_valid, out_stall, vertex/pos/normal   | item out
//   config   | psel, penable, pwrite, paddr, pwdata, ... | register access
//
// one item at a time: each result passes selection, position and output steps,
// and an interior vertex also waits for the iterative normal unit
// (shift search, three squares, 27-step root, three 17-step divisions)
// synchronous reset clears counters, window and registers to defaults
// in_stall is high from acceptance until the line buffers are updated
module heightfield_vertex_normal_gen (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hvng_pkg::HW-1:0]    height,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        vertex_col,
  output logic [7:0]                        vertex_row,
  output logic signed [hvng_pkg::PosW-1:0]  pos_x,
  output logic signed [hvng_pkg::HW-1:0]    pos_y,
  output logic signed [hvng_pkg::PosW-1:0]  pos_z,
  output logic signed [hvng_pkg::NrmW-1:0]  normal_x,
  output logic signed [hvng_pkg::NrmW-1:0]  normal_y,
  output logic signed [hvng_pkg::NrmW-1:0]  normal_z,
  output logic                              run_last,
  output logic                              grid_done,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [hvng_pkg::AddrW-1:0]        paddr,
  input  logic [hvng_pkg::DataW-1:0]        pwdata,
  output logic [hvng_pkg::DataW-1:0]        prdata,
  output logic                              pready
);
  import hvng_pkg::*;

  cfg_t     cfg;
  cmd_t     cmd;
  status_t  status;
  reg_idx_t ridx;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blocks_across <= 8'd8;
      cfg.blocks_down   <= 8'd8;
      cfg.cell_width    <= 16'd256;
      cfg.cell_depth    <= 16'd256;
    end else if (psel && penable && pwrite && pready) begin
      unique case (ridx)
        REG_BLOCKS_ACROSS: cfg.blocks_across <= pwdata[7:0];
        REG_BLOCKS_DOWN:   cfg.blocks_down   <= pwdata[7:0];
        REG_CELL_WIDTH:    cfg.cell_width    <= pwdata[15:0];
        REG_CELL_DEPTH:    cfg.cell_depth    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_BLOCKS_ACROSS: prdata = {24'b0, cfg.blocks_across};
      REG_BLOCKS_DOWN:   prdata = {24'b0, cfg.blocks_down};
      REG_CELL_WIDTH:    prdata = {16'b0, cfg.cell_width};
      REG_CELL_DEPTH:    prdata = {16'b0, cfg.cell_depth};
      default:           prdata = '0;
    endcase
  end

  hvng_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  hvng_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd        (cmd),
    .status     (status),
    .height     (height),
    .vertex_col (vertex_col),
    .vertex_row (vertex_row),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .normal_x   (normal_x),
    .normal_y   (normal_y),
    .normal_z   (normal_z),
    .run_last   (run_last),
    .grid_done  (grid_done)
  );

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("result offered while intake open");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && grid_done) |-> run_last)
    else $error("grid end not on last result of item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (in_stall && !out_valid))
    else $error("intake not closed after acceptance");

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for heightfield_vertex_normal_gen, driving
// whole height grids and checking every vertex against an in-bench predictor
// depends on hvng_pkg and the heightfield_vertex_normal_gen rtl
module tb_top;
  import hvng_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 300;
  localparam int HoldCycles = 400;

  typedef struct packed {
    logic [7:0]  col;
    logic [7:0]  row;
    logic [24:0] px;
    logic [15:0] py;
    logic [24:0] pz;
    logic [15:0] nx;
    logic [15:0] ny;
    logic [15:0] nz;
    logic        last;
    logic        done;
  } vertex_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [HW-1:0] height = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] vertex_col, vertex_row;
  logic signed [PosW-1:0] pos_x, pos_z;
  logic signed [HW-1:0] pos_y;
  logic signed [NrmW-1:0] normal_x, normal_y, normal_z;
  logic run_last, grid_done;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic pready;

  heightfield_vertex_normal_gen dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  vertex_t pending_vertices[$];
  int errors = 0;
  int heights_sent = 0;
  int vertices_seen = 0;
  int grids_run = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;

  // predictor state
  logic [7:0]  cfg_across = 8'd8, cfg_down = 8'd8;
  logic [15:0] cfg_cw = 16'd256, cfg_cd = 16'd256;
  logic signed [15:0] older_rows[MaxVertsPerRow];
  logic signed [15:0] newer_rows[MaxVertsPerRow];
  logic signed [15:0] win[6];
  int col_count = 0, row_count = 0;

  initial begin
    foreach (older_rows[i]) begin
      older_rows[i] = '0;
      newer_rows[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void unit_normal(input longint v[3], output longint n[3]);
    longint unsigned m[3], mx, s2, len, q;
    int sh;
    mx = 0;
    s2 = 0;
    sh = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = (v[i] < 0) ? -v[i] : v[i];
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      n[0] = 0; n[1] = 16384; n[2] = 0;
      return;
    end
    while ((mx << sh) < (64'd1 << 17)) sh++;
    for (int i = 0; i < 3; i++) begin
      m[i] <<= sh;
      s2 += m[i] * m[i];
    end
    len = int_sqrt(s2 << 16);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd4194304 + len / 2) / len;
      if (q > 16384) q = 16384;
      n[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void add_vertex(int rv, int cv, logic signed [15:0] hc,
                                     logic signed [15:0] hl, logic signed [15:0] hr,
                                     logic signed [15:0] hu, logic signed [15:0] hd,
                                     int ncols, int nrows, bit done);
    vertex_t e;
    longint v[3], n[3], px, pz;
    px = (longint'(cfg_cw) * (2 * cv - (ncols - 1)) + 1) >>> 1;
    pz = (longint'(cfg_cd) * ((nrows - 1) - 2 * rv) + 1) >>> 1;
    if (cv == 0 || cv == ncols - 1 || rv == 0 || rv == nrows - 1) begin
      n[0] = 0; n[1] = 16384; n[2] = 0;
    end else begin
      v[0] = longint'(hl) - longint'(hr);
      v[1] = 2 * (longint'(cfg_cw) + longint'(cfg_cd));
      v[2] = longint'(hd) - longint'(hu);
      unit_normal(v, n);
    end
    e.col = cv[7:0];
    e.row = rv[7:0];
    e.px = px[24:0];
    e.py = hc;
    e.pz = pz[24:0];
    e.nx = n[0][15:0];
    e.ny = n[1][15:0];
    e.nz = n[2][15:0];
    e.last = 1'b0;
    e.done = done;
    pending_vertices.push_back(e);
  endfunction

  function automatic void predict_vertices(logic signed [15:0] h);
    int ncols, nrows, c, r, prev_size;
    logic signed [15:0] top, mid;
    ncols = int'(cfg_across) + 1;
    nrows = int'(cfg_down) + 1;
    if (ncols > MaxVertsPerRow) ncols = MaxVertsPerRow;
    c = (col_count > ncols - 1) ? ncols - 1 : col_count;
    r = (row_count > nrows - 1) ? nrows - 1 : row_count;
    top = older_rows[c];
    mid = newer_rows[c];
    prev_size = pending_vertices.size();
    if (r >= 1 && c >= 1)
      add_vertex(r - 1, c - 1, win[1], win[4], mid, win[0], win[2], ncols, nrows, 0);
    if (r >= 1 && c == ncols - 1)
      add_vertex(r - 1, c, mid, 0, 0, 0, 0, ncols, nrows, 0);
    if (r == nrows - 1 && c >= 1)
      add_vertex(r, c - 1, win[2], 0, 0, 0, 0, ncols, nrows, 0);
    if (r == nrows - 1 && c == ncols - 1)
      add_vertex(r, c, h, 0, 0, 0, 0, ncols, nrows, 1);
    if (pending_vertices.size() > prev_size)
      pending_vertices[pending_vertices.size() - 1].last = 1'b1;
    older_rows[c] = mid;
    newer_rows[c] = h;
    win[3] = win[0];
    win[4] = win[1];
    win[5] = win[2];
    win[0] = top;
    win[1] = mid;
    win[2] = h;
    if (c >= ncols - 1) begin
      col_count = 0;
      row_count = (r >= nrows - 1) ? 0 : ((r + 1) & 8'hFF);
    end else begin
      col_count = (c + 1) & 8'hFF;
      row_count = r;
    end
  endfunction

  // receiver: random stalls, plus one long hold when asked
  always @(posedge clk) begin : recv_side
    int hold_left;
    if (hold_req && hold_left == 0 && out_valid) hold_left = HoldCycles;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 1'b0;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_idle_pct > 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    vertex_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = {vertex_col, vertex_row, pos_x, pos_y, pos_z, normal_x, normal_y,
             normal_z, run_last, grid_done};
      vertices_seen++;
      if (pending_vertices.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected vertex: %p", got);
      end else begin
        want = pending_vertices.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) quiet = 0;
    else quiet++;
    if (quiet >= StallLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_height(logic signed [15:0] h);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    height <= h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_vertices(h);
    heights_sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrW'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BLOCKS_ACROSS: cfg_across = value[7:0];
      REG_BLOCKS_DOWN:   cfg_down = value[7:0];
      REG_CELL_WIDTH:    cfg_cw = value[15:0];
      default:           cfg_cd = value[15:0];
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_vertices.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_height(int style, int k);
    logic signed [15:0] corner[5] = '{-16'sd32768, 16'sd32767, 16'sd0, -16'sd1, 16'sd1};
    case (style)
      0: return 16'($urandom_range(65535));
      1: return corner[k % 5];
      default: return 16'($signed($urandom_range(600)) - 300);
    endcase
  endfunction

  task automatic run_grid(int across, int down, int cw, int cd, int style);
    wait_idle();
    write_reg(REG_BLOCKS_ACROSS, across);
    write_reg(REG_BLOCKS_DOWN, down);
    write_reg(REG_CELL_WIDTH, cw);
    write_reg(REG_CELL_DEPTH, cd);
    for (int k = 0; k < (across + 1) * (down + 1); k++)
      send_height(pick_height(($urandom_range(9) == 0) ? 1 : style, k));
    grids_run++;
  endtask

  function automatic int pick_cell();
    case ($urandom_range(3))
      0: return 1;
      1: return 65535;
      default: return $urandom_range(1, 65535);
    endcase
  endfunction

  task automatic test_directed();
    run_grid(1, 1, 256, 256, 1);
    run_grid(2, 2, 1, 1, 1);
    run_grid(3, 2, 65535, 65535, 1);
  endtask

  task automatic test_random_grids(int count);
    int target;
    target = heights_sent + count;
    while (heights_sent < target)
      run_grid($urandom_range(1, 6), $urandom_range(1, 6), pick_cell(), pick_cell(),
               $urandom_range(2));
  endtask

  task automatic test_wide_and_tall();
    run_grid(16, 1, pick_cell(), pick_cell(), 0);
    run_grid(1, 16, pick_cell(), pick_cell(), 2);
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_req = 1'b1;
    run_grid(5, 5, $urandom_range(1, 65535), $urandom_range(1, 65535), 2);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 38;
    recv_idle_pct = 66;
    test_directed();
    test_random_grids(25);
    send_idle_pct = 66;
    recv_idle_pct = 38;
    test_random_grids(25);
    test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_grids(25);
    test_wide_and_tall();
    wait_idle();
    errors += pending_vertices.size();
    $display("covered %0d grids, %0d heights in, %0d vertices out",
             grids_run, heights_sent, vertices_seen);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> sim.f
rtl/hvng_pkg.sv
rtl/hvng_norm.sv
rtl/hvng_datapath.sv
rtl/hvng_ctrl.sv
rtl/heightfield_vertex_normal_gen.sv
tb/tb_top.sv
